FILE: src/assert_macros.svh
// assertion macros shared by the duration parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge of clk outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising edge of clk outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dsp_pkg.sv
// types, unit word tables and helpers for the duration string parser
package dsp_pkg;

  localparam int NUM_WORDS  = 11;
  localparam int WORD_IDX_W = 4;
  localparam int MAX_LEN    = 11;
  localparam int WORD_BITS  = 8 * MAX_LEN;
  localparam int POS_W      = 4;
  localparam int NUM_UNITS  = 4;
  localparam int VAL_W      = 63;
  localparam int ACC_W      = 68;
  localparam int SCALE_W    = 22;
  localparam int DTERM_W    = 26;

  typedef logic [7:0]       char_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_MAX = 4'd15;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_DIGITS,
    PH_SUFFIX
  } phase_t;

  typedef enum logic [1:0] {
    MULT_MS,
    MULT_SEC,
    MULT_MIN,
    MULT_HOUR
  } unit_t;

  // unit words, right aligned and zero padded
  localparam logic [WORD_BITS-1:0] WORD_TEXT [NUM_WORDS] = '{
    WORD_BITS'("ms"), WORD_BITS'("miliseconds"),
    WORD_BITS'("s"), WORD_BITS'("sec"), WORD_BITS'("seconds"), WORD_BITS'(0),
    WORD_BITS'("m"), WORD_BITS'("min"), WORD_BITS'("minutes"),
    WORD_BITS'("h"), WORD_BITS'("hour")
  };

  localparam pos_t WORD_LEN [NUM_WORDS] = '{
    4'd2, 4'd11,
    4'd1, 4'd3, 4'd7, 4'd0,
    4'd1, 4'd3, 4'd7,
    4'd1, 4'd4
  };

  localparam unit_t WORD_UNIT [NUM_WORDS] = '{
    MULT_MS, MULT_MS,
    MULT_SEC, MULT_SEC, MULT_SEC, MULT_SEC,
    MULT_MIN, MULT_MIN, MULT_MIN,
    MULT_HOUR, MULT_HOUR
  };

  localparam logic [SCALE_W-1:0] UNIT_SCALE [NUM_UNITS] = '{
    22'd1, 22'd1000, 22'd60000, 22'd3600000
  };

  typedef struct packed {
    logic add_digit;
    logic restart;
    logic feed;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic  found;
    unit_t unit;
  } match_t;

  typedef struct packed {
    logic range_ovf;
    logic prod_ovf;
    logic mag_nonzero;
    val_t product;
  } acc_t;

  // character of word w at position pos; zero past the end of the word
  function automatic char_t word_char(input logic [WORD_IDX_W-1:0] w, input pos_t pos);
    logic [WORD_BITS-1:0] aligned;
    aligned = WORD_TEXT[w] << (8 * (MAX_LEN - int'(WORD_LEN[w])));
    aligned = aligned << {pos, 3'b000};
    return aligned[WORD_BITS-1 -: 8];
  endfunction

  function automatic logic is_space(input char_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: src/dsp_if.sv
// valid/ready channel interfaces for the duration string parser
interface dsp_in_if;
  logic                valid;
  logic                ready;
  dsp_pkg::char_t      char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface dsp_out_if;
  logic                valid;
  logic                ready;
  logic                parse_error;
  dsp_pkg::val_t       duration_ms;

  modport source (output valid, output parse_error, output duration_ms, input ready);
  modport sink (input valid, input parse_error, input duration_ms, output ready);
endinterface

FILE: src/dsp_match.sv
// unit word matcher: tracks which words the suffix still agrees with
`include "assert_macros.svh"

module dsp_match (
  input  logic            clk,
  input  logic            rst_n,
  input  dsp_pkg::ctl_t   ctl,
  input  dsp_pkg::char_t  char_byte,
  output dsp_pkg::match_t match
);

  logic [dsp_pkg::NUM_WORDS-1:0] cand_r, cand_nxt;
  dsp_pkg::pos_t                 pos_r, pos_nxt;
  logic                          overlong_r, overlong_nxt;

  always_comb begin
    cand_nxt     = cand_r;
    pos_nxt      = pos_r;
    overlong_nxt = overlong_r;
    if (ctl.restart || ctl.finish) begin
      cand_nxt     = '1;
      pos_nxt      = '0;
      overlong_nxt = 1'b0;
    end else if (ctl.feed) begin
      for (int i = 0; i < dsp_pkg::NUM_WORDS; i++) begin
        cand_nxt[i] = cand_r[i] &&
                      (pos_r < dsp_pkg::WORD_LEN[dsp_pkg::WORD_IDX_W'(i)]) &&
                      (dsp_pkg::word_char(dsp_pkg::WORD_IDX_W'(i), pos_r) == char_byte);
      end
      if (pos_r != dsp_pkg::POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end else begin
        overlong_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r     <= '1;
      pos_r      <= '0;
      overlong_r <= 1'b0;
    end else begin
      cand_r     <= cand_nxt;
      pos_r      <= pos_nxt;
      overlong_r <= overlong_nxt;
    end
  end

  // lowest-numbered word of matching length wins
  always_comb begin
    match.found = 1'b0;
    match.unit  = dsp_pkg::MULT_SEC;
    for (int i = dsp_pkg::NUM_WORDS - 1; i >= 0; i--) begin
      if (cand_r[i] && !overlong_r &&
          (dsp_pkg::WORD_LEN[dsp_pkg::WORD_IDX_W'(i)] == pos_r)) begin
        match.found = 1'b1;
        match.unit  = dsp_pkg::WORD_UNIT[dsp_pkg::WORD_IDX_W'(i)];
      end
    end
  end

  `ASSERT_IMPL(a_overlong_pos, overlong_r, pos_r == dsp_pkg::POS_MAX, "overlong without full position")
  `ASSERT_NEXT(a_restart_clear, ctl.restart || ctl.finish, cand_r == '1 && pos_r == '0 && !overlong_r, "matcher not restarted")

endmodule

FILE: src/dsp_accum.sv
// decimal accumulator with one lane per unit scale and sticky overflow
`include "assert_macros.svh"

module dsp_accum (
  input  logic           clk,
  input  logic           rst_n,
  input  dsp_pkg::ctl_t  ctl,
  input  dsp_pkg::char_t char_byte,
  input  dsp_pkg::unit_t unit,
  output dsp_pkg::acc_t  acc
);

  dsp_pkg::val_t                 val_r [dsp_pkg::NUM_UNITS];
  logic [dsp_pkg::NUM_UNITS-1:0] ovf_r;
  logic [3:0]                    digit;

  assign digit = char_byte[3:0];

  for (genvar k = 0; k < dsp_pkg::NUM_UNITS; k++) begin : g_lane
    logic [dsp_pkg::ACC_W-1:0]   ext;
    logic [dsp_pkg::ACC_W-1:0]   sum;
    logic [dsp_pkg::DTERM_W-1:0] dterm;
    logic                        over;

    // lane k holds value * scale; times ten is two shifted adds
    assign ext   = dsp_pkg::ACC_W'(val_r[k]);
    assign dterm = dsp_pkg::DTERM_W'(digit) * dsp_pkg::DTERM_W'(dsp_pkg::UNIT_SCALE[k]);
    assign sum   = (ext << 3) + (ext << 1) + dsp_pkg::ACC_W'(dterm);
    assign over  = |sum[dsp_pkg::ACC_W-1:dsp_pkg::VAL_W];

    always_ff @(posedge clk) begin
      if (!rst_n || ctl.finish) begin
        val_r[k] <= '0;
        ovf_r[k] <= 1'b0;
      end else if (ctl.add_digit && !ovf_r[k]) begin
        if (over) begin
          ovf_r[k] <= 1'b1;
        end else begin
          val_r[k] <= sum[dsp_pkg::VAL_W-1:0];
        end
      end
    end
  end

  assign acc.range_ovf   = ovf_r[dsp_pkg::MULT_MS];
  assign acc.prod_ovf    = ovf_r[unit];
  assign acc.mag_nonzero = |val_r[dsp_pkg::MULT_MS];
  assign acc.product     = val_r[unit];

  `ASSERT_IMPL(a_ovf_order, ovf_r[dsp_pkg::MULT_MS], &ovf_r[dsp_pkg::NUM_UNITS-1:1], "range overflow without product overflow")
  `ASSERT_IMPL(a_ovf_scale, ovf_r[dsp_pkg::MULT_SEC], ovf_r[dsp_pkg::MULT_MIN] && ovf_r[dsp_pkg::MULT_HOUR], "overflow order broken")

endmodule

FILE: src/duration_string_parser.sv
// duration string parser top level: input register, phase control, result register
// a terminating NUL passes through the input register, then loads the result register and sets it valid
// throughput: one byte per cycle unless a NUL byte waits on an untaken result
// the result register frees the input side for all bytes but a NUL while a result waits to be taken
// synchronous active-low reset returns the parser to the leading white space phase
`include "assert_macros.svh"

module duration_string_parser (
  input  logic        clk,
  input  logic        rst_n,
  dsp_in_if.sink      in_ch,
  dsp_out_if.source   out_ch
);

  logic             in_valid_r;
  dsp_pkg::char_t   in_byte_r;
  dsp_pkg::phase_t  phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic             any_byte_r, any_byte_nxt;
  logic             out_valid_r;
  logic             out_err_r;
  dsp_pkg::val_t    out_dur_r;

  logic             consume;
  logic             is_nul;
  logic             digit_run;
  logic             sign_char;
  logic             err;
  dsp_pkg::ctl_t    ctl;
  dsp_pkg::match_t  match;
  dsp_pkg::acc_t    acc;

  assign is_nul    = (in_byte_r == dsp_pkg::CH_NUL);
  assign digit_run = dsp_pkg::is_digit(in_byte_r) && (phase_r != dsp_pkg::PH_SUFFIX);
  assign sign_char = (in_byte_r == dsp_pkg::CH_PLUS) || (in_byte_r == dsp_pkg::CH_MINUS);

  // a NUL byte waits while an untaken result sits in the output register
  assign consume     = in_valid_r && (!is_nul || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.char_byte;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (consume) begin
      if (is_nul) begin
        phase_nxt = dsp_pkg::PH_SPACE;
      end else if (digit_run) begin
        phase_nxt = dsp_pkg::PH_DIGITS;
      end else begin
        unique case (phase_r)
          dsp_pkg::PH_SPACE: begin
            if (dsp_pkg::is_space(in_byte_r)) begin
              phase_nxt = dsp_pkg::PH_SPACE;
            end else if (sign_char) begin
              phase_nxt = dsp_pkg::PH_SIGNED;
            end else begin
              phase_nxt = dsp_pkg::PH_SUFFIX;
            end
          end
          dsp_pkg::PH_SIGNED: phase_nxt = dsp_pkg::PH_SUFFIX;
          dsp_pkg::PH_DIGITS: phase_nxt = dsp_pkg::PH_SUFFIX;
          dsp_pkg::PH_SUFFIX: phase_nxt = dsp_pkg::PH_SUFFIX;
          default:            phase_nxt = dsp_pkg::PH_SUFFIX;
        endcase
      end
    end
  end

  // control outputs
  always_comb begin
    ctl.finish    = consume && is_nul;
    ctl.add_digit = consume && !is_nul && digit_run;
    ctl.restart   = ctl.add_digit;
    ctl.feed      = consume && !is_nul && !digit_run;

    neg_nxt      = neg_r;
    any_byte_nxt = any_byte_r;
    if (ctl.finish) begin
      neg_nxt      = 1'b0;
      any_byte_nxt = 1'b0;
    end else if (consume) begin
      any_byte_nxt = 1'b1;
      if (!digit_run && (phase_r == dsp_pkg::PH_SPACE) && sign_char) begin
        neg_nxt = (in_byte_r == dsp_pkg::CH_MINUS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dsp_pkg::PH_SPACE;
      neg_r      <= 1'b0;
      any_byte_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      any_byte_r <= any_byte_nxt;
    end
  end

  dsp_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .char_byte (in_byte_r),
    .match     (match)
  );

  dsp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .char_byte (in_byte_r),
    .unit      (match.unit),
    .acc       (acc)
  );

  // minus zero passes: only a nonzero magnitude makes a negative value an error
  assign err = !any_byte_r || acc.range_ovf || (neg_r && acc.mag_nonzero) ||
               !match.found || acc.prod_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_err_r <= err;
      out_dur_r <= err ? '0 : acc.product;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.parse_error = out_err_r;
  assign out_ch.duration_ms = out_dur_r;

  `ASSERT_IMPL(a_err_zero, out_valid_r && out_err_r, out_dur_r == '0, "error result with nonzero duration")
  `ASSERT_NEXT(a_finish_out, ctl.finish, out_valid_r && phase_r == dsp_pkg::PH_SPACE && !any_byte_r, "result not loaded or state not cleared")
  `ASSERT_IMPL(a_no_overwrite, out_valid_r && !out_ch.ready, !ctl.finish, "pending result overwritten")

endmodule

FILE: bench/tb.sv
// self-checking bench for the duration string parser: byte stream in, one duration per string out
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WORD_COUNT   = 11;
  localparam logic [63:0] VALUE_MAX_64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          DRAIN_MARK   = -1;
  localparam int          TAIL_BYTES   = 100;
  localparam int          SETTLE       = 8;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic          err;
    dsp_pkg::val_t dur;
  } duration_result_t;

  string unit_names [WORD_COUNT] = '{
    "ms", "miliseconds", "s", "sec", "seconds", "", "m", "min", "minutes", "h", "hour"
  };
  longint unsigned unit_mult [WORD_COUNT] = '{
    1, 1, 1000, 1000, 1000, 1000, 60000, 60000, 60000, 3600000, 3600000
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dsp_in_if  in_ch ();
  dsp_out_if out_ch ();

  duration_string_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  dsp_pkg::phase_t       phase;
  logic [63:0]           mag;
  logic                  range_hit;
  logic                  negative;
  logic                  seen_digit;
  logic                  seen_byte;
  dsp_pkg::pos_t         spos;
  logic                  spos_sat;
  logic [WORD_COUNT-1:0] cand;

  duration_result_t pending_durations [$];
  int               text_bytes [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               stim_bytes = 0;
  int               stim_strings = 0;
  bit               byte_taken = 0;
  bit               tail_quiet = 0;
  int               src_gap = 0;
  int               snk_gap = 0;

  task automatic restart_words();
    spos     = '0;
    spos_sat = 1'b0;
    cand     = '1;
  endtask

  task automatic clear_parse();
    phase      = dsp_pkg::PH_SPACE;
    mag        = '0;
    range_hit  = 1'b0;
    negative   = 1'b0;
    seen_digit = 1'b0;
    seen_byte  = 1'b0;
    restart_words();
  endtask

  task automatic parse_step(input dsp_pkg::char_t c);
    duration_result_t res;
    logic [63:0]      val;
    logic [63:0]      mult;
    logic [63:0]      d;
    logic             found;
    logic             err;
    if (c != dsp_pkg::CH_NUL) begin
      seen_byte = 1'b1;
      if (c >= dsp_pkg::CH_ZERO && c <= dsp_pkg::CH_NINE && phase != dsp_pkg::PH_SUFFIX) begin
        phase      = dsp_pkg::PH_DIGITS;
        seen_digit = 1'b1;
        d          = 64'(c - dsp_pkg::CH_ZERO);
        if (!range_hit) begin
          if (mag > (VALUE_MAX_64 - d) / 64'd10) range_hit = 1'b1;
          else mag = mag * 64'd10 + d;
        end
        restart_words();
      end else begin
        if (phase == dsp_pkg::PH_SPACE && (c == dsp_pkg::CH_PLUS || c == dsp_pkg::CH_MINUS)) begin
          phase    = dsp_pkg::PH_SIGNED;
          negative = (c == dsp_pkg::CH_MINUS);
        end else if (!(phase == dsp_pkg::PH_SPACE &&
                       (c == dsp_pkg::CH_SPACE ||
                        (c >= dsp_pkg::CH_TAB && c <= dsp_pkg::CH_CR)))) begin
          phase = dsp_pkg::PH_SUFFIX;
        end
        for (int i = 0; i < WORD_COUNT; i++) begin
          if (cand[i] && (spos >= unit_names[i].len() || unit_names[i][spos] != c))
            cand[i] = 1'b0;
        end
        if (spos < dsp_pkg::POS_MAX) spos++;
        else spos_sat = 1'b1;
      end
    end else begin
      val   = seen_digit ? mag : 64'd0;
      err   = !seen_byte || range_hit || (negative && val != 64'd0);
      found = 1'b0;
      mult  = 64'd0;
      for (int i = 0; i < WORD_COUNT; i++) begin
        if (!found && cand[i] && unit_names[i].len() == int'(spos) && !spos_sat) begin
          found = 1'b1;
          mult  = unit_mult[i];
        end
      end
      if (!found) err = 1'b1;
      if (!err && val > VALUE_MAX_64 / mult) err = 1'b1;
      res.err = err;
      res.dur = err ? '0 : dsp_pkg::val_t'(val * mult);
      pending_durations.push_back(res);
      clear_parse();
    end
  endtask

  // stimulus helpers
  task automatic push_byte(input int b);
    text_bytes.push_back(b);
    stim_bytes++;
  endtask

  task automatic push_chars(input string s);
    for (int k = 0; k < s.len(); k++) push_byte(int'(s[k]));
  endtask

  task automatic end_text();
    push_byte(dsp_pkg::CH_NUL);
    stim_strings++;
  endtask

  task automatic add_text(input string s);
    push_chars(s);
    end_text();
  endtask

  task automatic add_random_text();
    int              kind;
    int              w;
    int              sgn;
    int              mode;
    int              c;
    longint unsigned v;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // noise: arbitrary nonzero bytes
      repeat ($urandom_range(1, 20)) push_byte($urandom_range(1, 255));
      end_text();
    end else begin
      w = $urandom_range(0, WORD_COUNT - 1);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          c = $urandom_range(8, 13);
          push_byte(c == 8 ? int'(dsp_pkg::CH_SPACE) : c);
        end
      end
      sgn = $urandom_range(0, 9);
      if (sgn < 2) push_byte(dsp_pkg::CH_PLUS);
      else if (sgn == 2) push_byte(dsp_pkg::CH_MINUS);
      mode = $urandom_range(0, 9);
      if (sgn == 2 && $urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(dsp_pkg::CH_ZERO);
      end else if (mode == 1) begin
        // around the product overflow boundary for this unit
        v = 64'h7FFF_FFFF_FFFF_FFFF / unit_mult[w];
        v = v + longint'($urandom_range(0, 2));
        v = v - 1;
        push_chars($sformatf("%0d", v));
      end else if (mode == 2) begin
        repeat ($urandom_range(18, 22))
          push_byte(int'(dsp_pkg::CH_ZERO) + $urandom_range(0, 9));
      end else if (mode != 0) begin
        repeat ($urandom_range(1, 6))
          push_byte(int'(dsp_pkg::CH_ZERO) + $urandom_range(0, 9));
      end
      push_chars(unit_names[w]);
      if ($urandom_range(0, 9) == 0) push_byte($urandom_range(1, 255));
      end_text();
    end
  endtask

  // input driver
  always @(negedge clk) begin
    logic           nv;
    dsp_pkg::char_t nb;
    if (rst_n !== 1'b1) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_byte <= dsp_pkg::CH_NUL;
    end else begin
      nv = in_ch.valid;
      nb = in_ch.char_byte;
      if (!in_ch.valid || byte_taken) begin
        nv = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (text_bytes.size() > 0) begin
          if (text_bytes[0] == DRAIN_MARK) begin
            // hold off until every duration has come back
            if (pending_durations.size() == 0) void'(text_bytes.pop_front());
          end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            src_gap = $urandom_range(0, 16);
          end else begin
            nv = 1'b1;
            nb = dsp_pkg::char_t'(text_bytes.pop_front());
          end
        end
      end
      byte_taken = 0;
      in_ch.valid     <= nv;
      in_ch.char_byte <= nb;
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    logic nr;
    if (rst_n !== 1'b1) begin
      nr = 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      nr = 1'b0;
    end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 16);
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    out_ch.ready <= nr;
  end

  // monitor: predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    duration_result_t want;
    if (rst_n === 1'b1) begin
      cycle_count++;
      if (in_ch.valid && in_ch.ready) begin
        parse_step(in_ch.char_byte);
        byte_taken = 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_durations.size() == 0) begin
          $display("%0t: result expected none actual error %0b duration %0d",
                   $time, out_ch.parse_error, out_ch.duration_ms);
          mismatch_count++;
        end else begin
          want = pending_durations.pop_front();
          if (out_ch.parse_error !== want.err) begin
            $display("%0t: parse_error expected %0b actual %0b",
                     $time, want.err, out_ch.parse_error);
            mismatch_count++;
          end
          if (out_ch.duration_ms !== want.dur) begin
            $display("%0t: duration_ms expected %0d actual %0d",
                     $time, want.dur, out_ch.duration_ms);
            mismatch_count++;
          end
        end
      end
      tail_quiet = (text_bytes.size() < TAIL_BYTES);
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.char_byte = dsp_pkg::CH_NUL;
    out_ch.ready    = 1'b0;
    clear_parse();

    // directed strings
    add_text("");
    add_text("0");
    add_text("5");
    add_text("ms");
    add_text("-000s");
    add_text("-5");
    add_text("+7m");
    push_byte(dsp_pkg::CH_SPACE);
    for (int c = dsp_pkg::CH_TAB; c <= dsp_pkg::CH_CR; c++) push_byte(c);
    add_text("12h");
    add_text("9223372036854775807ms");
    add_text("9223372036854775808ms");
    add_text("-99999999999999999999");
    add_text("9223372036854775807s");
    add_text("9223372036854775s");
    add_text("10miliseconds");
    add_text("3sec");
    add_text("2seconds");
    add_text("4min");
    add_text("6minutes");
    add_text("1hour");
    add_text("5xyz");
    add_text("5aaaaaaaaaaaaaaaaaaaa");
    add_text("5s5");
    add_text("--5");
    add_text("   ms");
    push_byte(8'hFF);
    push_byte(8'h80);
    end_text();
    text_bytes.push_back(DRAIN_MARK);

    while (stim_bytes < 550 || stim_strings < 60) begin
      add_random_text();
      if (stim_strings % 25 == 0) text_bytes.push_back(DRAIN_MARK);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((text_bytes.size() > 0 || in_ch.valid || pending_durations.size() > 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
    end else begin
      repeat (SETTLE) @(posedge clk);
      if (mismatch_count == 0 && pending_durations.size() == 0)
        $display("end of test: clean");
      else
        $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
